FILE: src/zsf_pkg.sv
// zsf_pkg: shared types and constants for the zone speed factor unit.
// Used by zsf_front, zsf_back and zone_speed_factor_unit.
package zsf_pkg;

  localparam int EFFECT_W    = 2;
  localparam int CURVE_W     = 3;
  localparam int INTENSITY_W = 7;
  localparam int PROGRESS_W  = 17;
  localparam int FACTOR_W    = 20;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [EFFECT_W-1:0] EFFECT_NONE  = 2'd0;
  localparam logic [EFFECT_W-1:0] EFFECT_DECEL = 2'd1;

  localparam logic [CURVE_W-1:0] CURVE_RAMP   = 3'd0;
  localparam logic [CURVE_W-1:0] CURVE_COS    = 3'd1;
  localparam logic [CURVE_W-1:0] CURVE_SQ     = 3'd2;
  localparam logic [CURVE_W-1:0] CURVE_SIN    = 3'd3;

  localparam logic [INTENSITY_W-1:0] INTENSITY_MAX = 7'd100;
  localparam int                     INTENSITY_N   = 101;

  localparam logic [FACTOR_W-1:0] FACTOR_MAX = {FACTOR_W{1'b1}};

  // half pi in Q2.30 and the Taylor divisors (2k)(2k+1)
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam int              TAYLOR_TERMS = 10;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

  typedef enum logic [1:0] {EFF_NONE, EFF_DECEL, EFF_ACCEL} effect_kind_t;
  typedef enum logic [1:0] {CRV_LINEAR, CRV_COS, CRV_SQ, CRV_SIN} curve_kind_t;

  typedef struct packed {
    effect_kind_t eff;
    curve_kind_t  crv;
    logic         cos_neg;
  } ctl_t;

endpackage

FILE: src/zsf_queue.sv
// zsf_queue: two-entry request queue between front and back.
// Depends on nothing but its width parameter.
module zsf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         push;
  logic         pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: src/zsf_front.sv
// zsf_front: accepts items, saturates inputs, classifies effect and curve,
// forms the sine table index and the intensity coefficient. Uses zsf_pkg.
module zsf_front #(
  parameter int FRAC_BITS        = 16,
  parameter int TRIG_TABLE_DEPTH = 256,
  parameter int AW               = 9
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [zsf_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              q_valid,
  input  logic                              q_ready,
  output zsf_pkg::ctl_t                     q_ctl,
  output logic [FRAC_BITS:0]                q_p,
  output logic [AW-1:0]                     q_idx,
  output logic [FRAC_BITS+3:0]              q_coef
);

  localparam int              CW   = FRAC_BITS + 4;
  localparam longint unsigned ONE  = 64'd1 << FRAC_BITS;
  localparam longint unsigned HALF = ONE >> 1;
  localparam longint unsigned DEP  = 64'(TRIG_TABLE_DEPTH);

  logic [CW-1:0] pm1_tab [zsf_pkg::INTENSITY_N];
  logic [CW-1:0] k_tab   [zsf_pkg::INTENSITY_N];

  for (genvar gi = 0; gi < zsf_pkg::INTENSITY_N; gi++) begin : g_coef
    localparam longint unsigned PM1 = (64'(9 * gi) * ONE + 64'd50) / 64'd100;
    localparam longint unsigned DEN = 64'(100 + 9 * gi);
    localparam longint unsigned RCP = (64'd100 * ONE + DEN / 64'd2) / DEN;
    assign pm1_tab[gi] = CW'(PM1);
    assign k_tab[gi]   = CW'(ONE - RCP);
  end

  logic [zsf_pkg::EFFECT_W-1:0]    effect;
  logic [zsf_pkg::CURVE_W-1:0]     curve;
  logic [zsf_pkg::INTENSITY_W-1:0] inten;
  logic [zsf_pkg::INTENSITY_W-1:0] inten_sat;
  logic [63:0]                     p64;
  logic [63:0]                     q64;
  logic [63:0]                     a64;
  logic [63:0]                     sidx64;
  zsf_pkg::ctl_t                   ctl;
  logic [AW-1:0]                   idx;
  logic [CW-1:0]                   coef;

  logic                            fv;
  logic                            load;

  always_comb begin
    effect    = s_tdata[1:0];
    curve     = s_tdata[4:2];
    inten     = s_tdata[11:5];
    inten_sat = (inten > zsf_pkg::INTENSITY_MAX) ? zsf_pkg::INTENSITY_MAX : inten;
    p64       = 64'(s_tdata[28:12]);
    if (p64 > ONE) begin
      p64 = ONE;
    end
    q64    = ONE - p64;
    a64    = (p64 * 64'd2 * DEP + HALF) >> FRAC_BITS;
    sidx64 = (q64 * DEP + HALF) >> FRAC_BITS;

    if (effect == zsf_pkg::EFFECT_NONE) begin
      ctl.eff = zsf_pkg::EFF_NONE;
    end else if (effect == zsf_pkg::EFFECT_DECEL) begin
      ctl.eff = zsf_pkg::EFF_DECEL;
    end else begin
      ctl.eff = zsf_pkg::EFF_ACCEL;
    end
    unique case (curve)
      zsf_pkg::CURVE_RAMP: ctl.crv = zsf_pkg::CRV_LINEAR;
      zsf_pkg::CURVE_COS:  ctl.crv = zsf_pkg::CRV_COS;
      zsf_pkg::CURVE_SQ:   ctl.crv = zsf_pkg::CRV_SQ;
      zsf_pkg::CURVE_SIN:  ctl.crv = zsf_pkg::CRV_SIN;
      default:             ctl.crv = zsf_pkg::CRV_LINEAR;
    endcase
    ctl.cos_neg = (a64 > DEP);

    unique case (ctl.crv)
      zsf_pkg::CRV_COS: idx = ctl.cos_neg ? AW'(a64 - DEP) : AW'(DEP - a64);
      zsf_pkg::CRV_SIN: idx = AW'(sidx64);
      default:          idx = '0;
    endcase
    coef = (ctl.eff == zsf_pkg::EFF_DECEL) ? pm1_tab[inten_sat] : k_tab[inten_sat];
  end

  assign s_tready = !fv || q_ready;
  assign load     = s_tvalid && s_tready;
  assign q_valid  = fv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (s_tready) begin
      fv <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_ctl  <= ctl;
      q_p    <= p64[FRAC_BITS:0];
      q_idx  <= idx;
      q_coef <= coef;
    end
  end

endmodule

FILE: src/zsf_back.sv
// zsf_back: sine table lookup, curve value, coefficient multiply and output
// register. Uses zsf_pkg; fed from zsf_queue.
module zsf_back #(
  parameter int FRAC_BITS        = 16,
  parameter int TRIG_TABLE_DEPTH = 256,
  parameter int AW               = 9
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  zsf_pkg::ctl_t                  q_ctl,
  input  logic [FRAC_BITS:0]             q_p,
  input  logic [AW-1:0]                  q_idx,
  input  logic [FRAC_BITS+3:0]           q_coef,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [zsf_pkg::FACTOR_W-1:0]   factor
);

  localparam int              PW   = FRAC_BITS + 1;
  localparam int              CW   = FRAC_BITS + 4;
  localparam longint unsigned ONE  = 64'd1 << FRAC_BITS;
  localparam longint unsigned HALF = ONE >> 1;
  localparam logic [zsf_pkg::FACTOR_W-1:0] ONE_OUT =
    (ONE > 64'(zsf_pkg::FACTOR_MAX)) ? zsf_pkg::FACTOR_MAX : zsf_pkg::FACTOR_W'(ONE);

  function automatic logic [FRAC_BITS:0] sin_entry(input int unsigned i);
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    theta = (64'(i) * zsf_pkg::HALF_PI_Q30 + 64'(TRIG_TABLE_DEPTH / 2))
            / 64'(TRIG_TABLE_DEPTH);
    x2    = (theta * theta) >> 30;
    term  = theta;
    sum   = longint'(theta);
    for (int k = 0; k < zsf_pkg::TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> 30) / zsf_pkg::TAYLOR_DIV[k];
      if (k % 2 == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    r = (longint'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    if (r > ONE) begin
      r = ONE;
    end
    return PW'(r);
  endfunction

  logic [PW-1:0] sin_rom [TRIG_TABLE_DEPTH+1];

  for (genvar gi = 0; gi <= TRIG_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [PW-1:0] ENTRY = sin_entry(gi);
    assign sin_rom[gi] = ENTRY;
  end

  logic                 s1v;
  zsf_pkg::ctl_t        s1_ctl;
  logic [PW-1:0]        s1_c;
  logic [CW-1:0]        s1_coef;
  logic                 s2v;
  zsf_pkg::ctl_t        s2_ctl;
  logic                 s1_load;
  logic                 s2_load;

  logic [PW-1:0]        rom_val;
  logic [PW-1:0]        q;
  logic [2*PW-1:0]      sq;
  logic [PW:0]          cos_sum;
  logic [PW-1:0]        c;
  logic [PW-1:0]        mul_a;
  logic [PW+CW-1:0]     prod;
  logic [63:0]          term;
  logic [63:0]          f;
  logic [zsf_pkg::FACTOR_W-1:0] f_sat;

  assign s2_load = !s2v || m_tready;
  assign s1_load = !s1v || s2_load;
  assign q_ready = s1_load;

  always_comb begin
    rom_val = sin_rom[q_idx];
    q       = PW'(ONE) - q_p;
    sq      = (2*PW)'((64'(q) * 64'(q) + HALF) >> FRAC_BITS);
    cos_sum = q_ctl.cos_neg ? ((PW+1)'(ONE) - (PW+1)'(rom_val))
                            : ((PW+1)'(ONE) + (PW+1)'(rom_val));
    unique case (q_ctl.crv)
      zsf_pkg::CRV_COS: c = cos_sum[PW:1];
      zsf_pkg::CRV_SQ:  c = sq[PW-1:0];
      zsf_pkg::CRV_SIN: c = rom_val;
      default:          c = q;
    endcase
  end

  always_comb begin
    mul_a = (s1_ctl.eff == zsf_pkg::EFF_DECEL) ? s1_c : (PW'(ONE) - s1_c);
    prod  = (PW+CW)'(mul_a) * (PW+CW)'(s1_coef);
    term  = (64'(prod) + HALF) >> FRAC_BITS;
    unique case (s1_ctl.eff)
      zsf_pkg::EFF_DECEL: f = ONE + term;
      zsf_pkg::EFF_ACCEL: f = ONE - term;
      default:            f = ONE;
    endcase
    f_sat = (f > 64'(zsf_pkg::FACTOR_MAX)) ? zsf_pkg::FACTOR_MAX : f[zsf_pkg::FACTOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
    end else begin
      if (s1_load) begin
        s1v <= q_valid;
      end
      if (s2_load) begin
        s2v <= s1v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && q_valid) begin
      s1_ctl  <= q_ctl;
      s1_c    <= c;
      s1_coef <= q_coef;
    end
    if (s2_load && s1v) begin
      s2_ctl <= s1_ctl;
      factor <= f_sat;
    end
  end

  assign m_tvalid = s2v;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (rst) s2v && !m_tready |=> s2v)
    else $error("result dropped while stalled");
  a_none: assert property (@(posedge clk) disable iff (rst)
    s2v && s2_ctl.eff == zsf_pkg::EFF_NONE |-> factor == ONE_OUT)
    else $error("no-effect result is not unity");
  a_take: assert property (@(posedge clk) disable iff (rst) q_valid && q_ready |=> s1v)
    else $error("dequeued request lost");
`endif

endmodule

FILE: src/zone_speed_factor_unit.sv
// zone_speed_factor_unit: top level of the zone speed factor unit.
// Instantiates zsf_front, zsf_queue and zsf_back; uses zsf_pkg.
//
// Takes one request per cycle while s_tready is high and returns one speed
// factor per request, in order; each request passes through the input
// register, the two-entry queue, the table/curve stage and the
// multiply/output stage. The sine table and the intensity coefficient
// tables are constants built at elaboration; there is no clearing pass after
// reset.
module zone_speed_factor_unit #(
  parameter int FRAC_BITS        = 16,
  parameter int TRIG_TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // effect[1:0], curve[4:2], intensity[11:5], progress[28:12], zero fill
  input  logic [zsf_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // factor[19:0], zero fill
  output logic [zsf_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int AW = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int PW = FRAC_BITS + 1;
  localparam int CW = FRAC_BITS + 4;
  localparam int CTLW = $bits(zsf_pkg::ctl_t);
  localparam int QW = CTLW + PW + AW + CW;

  logic                          f_valid;
  logic                          f_ready;
  zsf_pkg::ctl_t                 f_ctl;
  logic [PW-1:0]                 f_p;
  logic [AW-1:0]                 f_idx;
  logic [CW-1:0]                 f_coef;
  logic                          b_valid;
  logic                          b_ready;
  logic [QW-1:0]                 b_data;
  logic [zsf_pkg::FACTOR_W-1:0]  factor;

  zsf_front #(
    .FRAC_BITS(FRAC_BITS),
    .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .q_valid(f_valid),
    .q_ready(f_ready),
    .q_ctl(f_ctl),
    .q_p(f_p),
    .q_idx(f_idx),
    .q_coef(f_coef)
  );

  zsf_queue #(
    .W(QW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data({f_ctl, f_p, f_idx, f_coef}),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_data(b_data)
  );

  zsf_back #(
    .FRAC_BITS(FRAC_BITS),
    .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(b_valid),
    .q_ready(b_ready),
    .q_ctl(b_data[QW-1 -: CTLW]),
    .q_p(b_data[AW+CW +: PW]),
    .q_idx(b_data[CW +: AW]),
    .q_coef(b_data[CW-1:0]),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .factor(factor)
  );

  assign m_tdata = {{(zsf_pkg::OUT_TDATA_W - zsf_pkg::FACTOR_W){1'b0}}, factor};

endmodule
